// ===== sv/lz11d_pkg.sv =====
package lz11d_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int SIZE_BITS    = 24;
    localparam int LEN_W        = 17;
    localparam int DIST_W       = 13;

    localparam logic [7:0]       HDR_ID    = 8'h11;
    localparam logic [LEN_W-1:0] LEN4_BIAS = 17'h111;
    localparam logic [LEN_W-1:0] LEN3_BIAS = 17'h11;
    localparam logic [LEN_W-1:0] LEN2_BIAS = 17'h1;
    localparam logic [3:0]       NIB_MASK  = 4'hF;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_ID     = 2'd1,
        ST_BAD_DIST   = 2'd2,
        ST_UNEXPECTED = 2'd3
    } status_t;

    typedef enum logic [7:0] {
        PH_ID    = 8'b0000_0001,
        PH_S0    = 8'b0000_0010,
        PH_S1    = 8'b0000_0100,
        PH_S2    = 8'b0000_1000,
        PH_FLAG  = 8'b0001_0000,
        PH_DATA  = 8'b0010_0000,
        PH_TOKEN = 8'b0100_0000,
        PH_DONE  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic              emit;
        logic              is_copy;
        logic              last;
        logic              pending;
        status_t           status;
        logic [WIN_AW-1:0] wr_addr;
        logic [WIN_AW-1:0] rd_addr;
    } dec_t;

endpackage

// ===== sv/lz11d_ram.sv =====
module lz11d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/lz11d_ctrl.sv =====
module lz11d_ctrl #(
    parameter int SIZE_BITS = lz11d_pkg::SIZE_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            mode,
    input  logic [7:0]      in_byte,
    input  logic            start_req,
    output lz11d_pkg::dec_t dec
);

    import lz11d_pkg::*;

    localparam logic [23:0] SIZE_MAX24 = 24'((32'd1 << SIZE_BITS) - 32'd1);

    phase_t               phase_reg, phase_next, c_phase;
    logic [7:0]           flag_reg, flag_next, c_flag;
    logic [3:0]           bits_reg, bits_next, c_bits;
    logic [23:0]          tok_reg, tok_next, c_tok;
    logic [2:0]           tok_cnt_reg, tok_cnt_next, c_tok_cnt;
    logic [2:0]           tok_need_reg, tok_need_next, c_tok_need;
    logic [15:0]          size_lo_reg, size_lo_next, c_size_lo;
    logic [SIZE_BITS-1:0] target_reg, target_next, c_target;
    logic [SIZE_BITS-1:0] prod_reg, prod_next, c_prod;
    logic [WIN_AW-1:0]    wp_reg, wp_next, c_wp;
    logic [LEN_W-1:0]     remain_reg, remain_next, c_remain;
    logic [DIST_W-1:0]    dist_reg, dist_next, c_dist;

    logic [SIZE_BITS-1:0] prod_inc;
    logic                 reach;
    logic [23:0]          full_size;
    logic [23:0]          sat_size;
    logic [LEN_W-1:0]     tok_len;
    logic [DIST_W-1:0]    tok_dist;
    logic [3:0]           hi_nib;
    logic [3:0]           bits_dec;

    // start of a new stream clears everything but the history
    always_comb
    begin
        c_phase    = start_req ? PH_ID : phase_reg;
        c_flag     = start_req ? 8'd0 : flag_reg;
        c_bits     = start_req ? 4'd0 : bits_reg;
        c_tok      = start_req ? 24'd0 : tok_reg;
        c_tok_cnt  = start_req ? 3'd0 : tok_cnt_reg;
        c_tok_need = start_req ? 3'd0 : tok_need_reg;
        c_size_lo  = start_req ? 16'd0 : size_lo_reg;
        c_target   = start_req ? '0 : target_reg;
        c_prod     = start_req ? '0 : prod_reg;
        c_wp       = start_req ? '0 : wp_reg;
        c_remain   = start_req ? '0 : remain_reg;
        c_dist     = start_req ? DIST_W'(1) : dist_reg;
    end

    always_comb
    begin
        prod_inc  = c_prod + 1'b1;
        reach     = (prod_inc >= c_target);
        full_size = {in_byte, c_size_lo};
        sat_size  = (full_size > SIZE_MAX24) ? SIZE_MAX24 : full_size;
        hi_nib    = in_byte[7:4];
        bits_dec  = c_bits - 4'd1;
        tok_dist  = {1'b0, c_tok[3:0] & NIB_MASK, in_byte} + DIST_W'(1);
        unique case (c_tok_need)
            3'd4:    tok_len = {1'b0, c_tok[19:4]} + LEN4_BIAS;
            3'd3:    tok_len = {9'd0, c_tok[11:4]} + LEN3_BIAS;
            default: tok_len = {13'd0, c_tok[7:4]} + LEN2_BIAS;
        endcase
    end

    always_comb
    begin
        phase_next    = c_phase;
        flag_next     = c_flag;
        bits_next     = c_bits;
        tok_next      = c_tok;
        tok_cnt_next  = c_tok_cnt;
        tok_need_next = c_tok_need;
        size_lo_next  = c_size_lo;
        target_next   = c_target;
        prod_next     = c_prod;
        wp_next       = c_wp;
        remain_next   = c_remain;
        dist_next     = c_dist;

        dec         = '0;
        dec.status  = ST_OK;
        dec.wr_addr = c_wp;
        dec.rd_addr = c_wp - c_dist[WIN_AW-1:0];

        if (mode)
        begin
            if (c_remain == '0 || c_phase == PH_DONE)
            begin
                dec.status = ST_UNEXPECTED;
            end
            else
            begin
                dec.emit    = 1'b1;
                dec.is_copy = 1'b1;
                remain_next = c_remain - 1'b1;
                wp_next     = c_wp + 1'b1;
                prod_next   = prod_inc;
                if (reach)
                begin
                    dec.last    = 1'b1;
                    phase_next  = PH_DONE;
                    remain_next = '0;
                end
            end
        end
        else if (c_phase == PH_DONE || c_remain != '0)
        begin
            dec.status = ST_UNEXPECTED;
        end
        else
        begin
            unique case (c_phase)
                PH_ID:
                begin
                    if (in_byte == HDR_ID)
                    begin
                        phase_next = PH_S0;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        dec.status = ST_BAD_ID;
                    end
                end
                PH_S0:
                begin
                    size_lo_next = {8'd0, in_byte};
                    phase_next   = PH_S1;
                end
                PH_S1:
                begin
                    size_lo_next = {in_byte, c_size_lo[7:0]};
                    phase_next   = PH_S2;
                end
                PH_S2:
                begin
                    target_next = sat_size[SIZE_BITS-1:0];
                    phase_next  = (sat_size == 24'd0) ? PH_DONE : PH_FLAG;
                end
                PH_FLAG:
                begin
                    flag_next  = in_byte;
                    bits_next  = 4'd8;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (!c_flag[7])
                    begin
                        bits_next  = bits_dec;
                        flag_next  = {c_flag[6:0], 1'b0};
                        phase_next = (bits_dec != 4'd0) ? PH_DATA : PH_FLAG;
                        dec.emit   = 1'b1;
                        wp_next    = c_wp + 1'b1;
                        prod_next  = prod_inc;
                        if (reach)
                        begin
                            dec.last   = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        tok_need_next = (hi_nib == 4'd0) ? 3'd3 :
                                        ((hi_nib == 4'd1) ? 3'd4 : 3'd2);
                        tok_next      = {16'd0, in_byte};
                        tok_cnt_next  = 3'd1;
                        phase_next    = PH_TOKEN;
                    end
                end
                PH_TOKEN:
                begin
                    if (c_tok_cnt + 3'd1 >= c_tok_need)
                    begin
                        tok_next     = '0;
                        tok_cnt_next = '0;
                        bits_next    = bits_dec;
                        flag_next    = {c_flag[6:0], 1'b0};
                        phase_next   = (bits_dec != 4'd0) ? PH_DATA : PH_FLAG;
                        if (24'(tok_dist) > 24'(c_prod))
                        begin
                            phase_next  = PH_DONE;
                            remain_next = '0;
                            dec.status  = ST_BAD_DIST;
                        end
                        else
                        begin
                            remain_next = tok_len;
                            dist_next   = tok_dist;
                        end
                    end
                    else
                    begin
                        tok_next     = {c_tok[15:0], in_byte};
                        tok_cnt_next = c_tok_cnt + 3'd1;
                    end
                end
                default:
                begin
                    dec.status = ST_UNEXPECTED;
                end
            endcase
        end

        dec.pending = (remain_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ID;
            flag_reg     <= '0;
            bits_reg     <= '0;
            tok_reg      <= '0;
            tok_cnt_reg  <= '0;
            tok_need_reg <= '0;
            size_lo_reg  <= '0;
            target_reg   <= '0;
            prod_reg     <= '0;
            wp_reg       <= '0;
            remain_reg   <= '0;
            dist_reg     <= DIST_W'(1);
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            flag_reg     <= flag_next;
            bits_reg     <= bits_next;
            tok_reg      <= tok_next;
            tok_cnt_reg  <= tok_cnt_next;
            tok_need_reg <= tok_need_next;
            size_lo_reg  <= size_lo_next;
            target_reg   <= target_next;
            prod_reg     <= prod_next;
            wp_reg       <= wp_next;
            remain_reg   <= remain_next;
            dist_reg     <= dist_next;
        end
    end

endmodule

// ===== sv/lz11_stream_decompressor.sv =====
// pipeline: an accepted item passes the s1 register, then the output register
// throughput: 1 item per cycle unless m_axis_tready stalls the output, copies of any distance included; the history
// ram has one write and one read per cycle, distance-one reads forwarded
// reset: rst_n clears stream state and the pipeline at once, no clearing pass;
// history contents are undefined until written
module lz11_stream_decompressor #(
    parameter int SIZE_BITS = lz11d_pkg::SIZE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic [1:0]  s_axis_tuser,   // mode, start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_data, copy_pending, status, zero fill
    output logic        m_axis_tuser,   // out_valid
    output logic        m_axis_tlast    // out_last
);

    import lz11d_pkg::*;

    logic       accept;
    dec_t       dec;
    logic [7:0] rd_data;
    logic       s1_adv;
    logic [7:0] s1_byte;
    logic       wr_en;

    logic       s1_valid_reg, s1_valid_next;
    dec_t       s1_dec_reg;
    logic [7:0] s1_lit_reg;
    logic       fwd_hit_reg;
    logic [7:0] fwd_data_reg;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_emit_reg;
    logic       out_last_reg;
    logic       out_pend_reg;
    status_t    out_status_reg;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    lz11d_ctrl #(
        .SIZE_BITS (SIZE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (s_axis_tuser[0]),
        .in_byte   (s_axis_tdata),
        .start_req (s_axis_tuser[1]),
        .dec       (dec)
    );

    assign s1_byte = s1_dec_reg.is_copy ? (fwd_hit_reg ? fwd_data_reg : rd_data)
                                        : s1_lit_reg;
    assign wr_en   = s1_adv && s1_dec_reg.emit;

    lz11d_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_dec_reg.wr_addr),
        .wr_data (s1_byte),
        .rd_en   (accept),
        .rd_addr (dec.rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // same-cycle write to the entry being read is forwarded
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dec_reg   <= dec;
            s1_lit_reg   <= s_axis_tdata;
            fwd_hit_reg  <= wr_en && (s1_dec_reg.wr_addr == dec.rd_addr);
            fwd_data_reg <= s1_byte;
        end
        if (s1_adv)
        begin
            out_data_reg   <= s1_dec_reg.emit ? s1_byte : 8'd0;
            out_emit_reg   <= s1_dec_reg.emit;
            out_last_reg   <= s1_dec_reg.last;
            out_pend_reg   <= s1_dec_reg.pending;
            out_status_reg <= s1_dec_reg.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_status_reg, out_pend_reg, out_data_reg};
    assign m_axis_tuser  = out_emit_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
